// ===== hw/rtl/serial_receive_fifo_overrun_count_defines.svh =====
// ----------------------------------------------------------------------------
// serial receive fifo assertion macros
// shared concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef SERIAL_RECEIVE_FIFO_OVERRUN_COUNT_DEFINES_SVH
`define SERIAL_RECEIVE_FIFO_OVERRUN_COUNT_DEFINES_SVH

// same-cycle implication
`define SRFOC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srfoc assertion failed");

// next-cycle implication
`define SRFOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srfoc assertion failed");

`endif

// ===== hw/rtl/srfoc_pkg.sv =====
// ----------------------------------------------------------------------------
// srfoc_pkg
// widths, codes and shared types of the serial receive fifo
// ----------------------------------------------------------------------------
package srfoc_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = 10;
    localparam int CNT_W      = (PTR_W > FILL_W) ? PTR_W : FILL_W;
    localparam int TAG_W      = 8;
    localparam int DATA_W     = 8;
    localparam int OVR_W      = 32;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [DATA_W-1:0] t_byte;

    typedef struct packed {
        logic  en;
        t_ptr  addr;
        t_byte data;
    } t_ram_wr;

    typedef struct packed {
        logic en;
        t_ptr addr;
    } t_ram_rd;

endpackage

// ===== hw/rtl/srfoc_if.sv =====
// ----------------------------------------------------------------------------
// srfoc channel interfaces
// valid/ready channels for the poll/read requests and their results
// ----------------------------------------------------------------------------
interface srfoc_in_if
    import srfoc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [TAG_W-1:0]  rx_tag;
    logic [DATA_W-1:0] rx_data;

    modport source (output valid, output operation, output rx_tag, output rx_data,
                    input ready);
    modport sink   (input valid, input operation, input rx_tag, input rx_data,
                    output ready);
endinterface

interface srfoc_out_if
    import srfoc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic              byte_dropped;
    logic [OVR_W-1:0]  overrun_total;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, output read_data, output read_valid,
                    output byte_dropped, output overrun_total, output fill_level,
                    input ready);
    modport sink   (input valid, input read_data, input read_valid,
                    input byte_dropped, input overrun_total, input fill_level,
                    output ready);
endinterface

// ===== hw/rtl/serial_receive_fifo_overrun_count.sv =====
// ----------------------------------------------------------------------------
// serial_receive_fifo_overrun_count
// receive ring buffer with tag gap overrun counting
// ----------------------------------------------------------------------------
// i_in carries one transaction per poll (operation 0, rx_tag, rx_data) or
// read request (operation 1). o_out returns exactly one result transaction
// per request, in order.
// a poll with a new tag adds the tag gap to a saturating 32-bit counter and
// pushes the byte, or flags it dropped when RING_DEPTH - 1 bytes are held.
// a read pops the oldest byte or answers read_valid 0 when empty.
// a poll or an empty read is registered into the output stage at the
// accepting edge (result visible next cycle); a read that pops passes the
// byte store's registered read port and ST_READ first and takes no new
// request until its byte is in the output stage. one poll per cycle
// while the output stage is not stalled.
// the output stage holds a result while o_out.ready is low; a new request is
// taken only once that stage is free or being drained in the same cycle.
// reset clears pointers, fill count, last tag and counter; the store itself
// needs no clearing since only written entries are ever popped.
// ----------------------------------------------------------------------------
module serial_receive_fifo_overrun_count
    import srfoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    srfoc_in_if.sink    i_in,
    srfoc_out_if.source o_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic              r_state, n_state;
    logic [TAG_W-1:0]  r_last_tag, n_last_tag;
    t_ptr              r_wp, n_wp;
    t_ptr              r_rp, n_rp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [OVR_W-1:0]  r_ovr, n_ovr;

    logic              r_out_valid, n_out_valid;
    t_byte             r_out_data, n_out_data;
    logic              r_out_rvalid, n_out_rvalid;
    logic              r_out_drop, n_out_drop;
    logic [OVR_W-1:0]  r_out_ovr, n_out_ovr;
    logic [FILL_W-1:0] r_out_fill, n_out_fill;

    logic              accept;
    logic              full;
    logic              empty;
    logic [TAG_W-1:0]  gap;
    logic [OVR_W:0]    ovr_sum;
    t_ram_wr           ram_wr;
    t_ram_rd           ram_rd;
    t_byte             ram_rdata;

    srfoc_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_rd    (ram_rd),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count == CNT_W'(RING_DEPTH - 1));
    assign empty      = (r_count == '0);
    assign gap        = i_in.rx_tag - r_last_tag - TAG_W'(1);
    assign ovr_sum    = {1'b0, r_ovr} + (OVR_W+1)'(gap);

    always_comb begin
        n_state      = r_state;
        n_last_tag   = r_last_tag;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_count      = r_count;
        n_ovr        = r_ovr;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_data   = r_out_data;
        n_out_rvalid = r_out_rvalid;
        n_out_drop   = r_out_drop;
        n_out_ovr    = r_out_ovr;
        n_out_fill   = r_out_fill;
        ram_wr       = '{en: 1'b0, addr: r_wp, data: i_in.rx_data};
        ram_rd       = '{en: 1'b0, addr: r_rp};

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_data   = '0;
                    n_out_rvalid = 1'b0;
                    n_out_drop   = 1'b0;
                    if (i_in.operation == OP_POLL) begin
                        if (i_in.rx_tag != r_last_tag) begin
                            n_last_tag = i_in.rx_tag;
                            n_ovr      = ovr_sum[OVR_W] ? '1 : ovr_sum[OVR_W-1:0];
                            if (full) begin
                                n_out_drop = 1'b1;
                            end else begin
                                ram_wr.en = 1'b1;
                                n_wp      = (r_wp == PTR_W'(RING_DEPTH - 1)) ?
                                            '0 : r_wp + PTR_W'(1);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        n_out_valid = 1'b1;
                    end else if (!empty) begin
                        // pop: byte arrives from the store next cycle
                        ram_rd.en   = 1'b1;
                        n_rp        = (r_rp == PTR_W'(RING_DEPTH - 1)) ?
                                      '0 : r_rp + PTR_W'(1);
                        n_count     = r_count - CNT_W'(1);
                        n_state     = ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                    n_out_ovr  = n_ovr;
                    n_out_fill = n_count[FILL_W-1:0];
                end
            end
            ST_READ: begin
                n_out_valid  = 1'b1;
                n_out_data   = ram_rdata;
                n_out_rvalid = 1'b1;
                n_out_drop   = 1'b0;
                n_out_ovr    = r_ovr;
                n_out_fill   = r_count[FILL_W-1:0];
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last_tag  <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_ovr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_tag  <= n_last_tag;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_count     <= n_count;
            r_ovr       <= n_ovr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_rvalid <= n_out_rvalid;
        r_out_drop   <= n_out_drop;
        r_out_ovr    <= n_out_ovr;
        r_out_fill   <= n_out_fill;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.read_data     = r_out_data;
    assign o_out.read_valid    = r_out_rvalid;
    assign o_out.byte_dropped  = r_out_drop;
    assign o_out.overrun_total = r_out_ovr;
    assign o_out.fill_level    = r_out_fill;

endmodule

// ===== hw/rtl/srfoc_ram.sv =====
// ----------------------------------------------------------------------------
// srfoc_ram
// ring byte store, one write and one registered read port
// ----------------------------------------------------------------------------
module srfoc_ram
    import srfoc_pkg::*;
(
    input  logic    i_clk,
    input  t_ram_wr i_wr,
    input  t_ram_rd i_rd,
    output t_byte   o_rdata
);

    t_byte mem [RING_DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/srfoc_chk.sv =====
// ----------------------------------------------------------------------------
// srfoc_chk
// port-level checks of the serial receive fifo, bound to the top level
// ----------------------------------------------------------------------------
`include "serial_receive_fifo_overrun_count_defines.svh"

module srfoc_chk
    import srfoc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_read_data,
    input logic              i_read_valid,
    input logic              i_byte_dropped,
    input logic [OVR_W-1:0]  i_overrun_total
);

    // stalled result holds
    `SRFOC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_read_data) && $stable(i_overrun_total))

    // a popped byte never comes with a drop flag
    `SRFOC_ASSERT_NOW(a_read_no_drop, i_clk, i_rst_n, i_out_valid && i_read_valid, !i_byte_dropped)

    // no byte means zero data
    `SRFOC_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_out_valid && !i_read_valid, i_read_data == '0)

    // overrun counter never goes down
    `SRFOC_ASSERT_NOW(a_ovr_mono, i_clk, i_rst_n, i_out_valid && $past(i_out_valid), i_overrun_total >= $past(i_overrun_total))

endmodule

bind serial_receive_fifo_overrun_count srfoc_chk u_srfoc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_read_data     (o_out.read_data),
    .i_read_valid    (o_out.read_valid),
    .i_byte_dropped  (o_out.byte_dropped),
    .i_overrun_total (o_out.overrun_total)
);

// ===== tb/tb_serial_receive_fifo_overrun_count.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_receive_fifo_overrun_count
// self-checking bench for the receive ring buffer with overrun counting
// ----------------------------------------------------------------------------
// each accepted poll or read transaction is run through a local model of the
// ring, the last tag and the saturating gap counter; the expected result is
// queued and every result transaction is compared field by field with the
// oldest entry. a directed part covers tag wrap, repeated tags, the largest
// gaps and empty reads; three random phases vary sender and receiver idling,
// then the ring is filled to overflow and a few bytes are read back.
// ----------------------------------------------------------------------------
module tb_serial_receive_fifo_overrun_count;
    import srfoc_pkg::*;

    localparam int ITEMS_PER_PHASE = 50;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        t_byte             read_data;
        logic              read_valid;
        logic              byte_dropped;
        logic [OVR_W-1:0]  overrun_total;
        logic [FILL_W-1:0] fill_level;
    } rx_result_t;

    class rx_fifo_scoreboard;
        t_byte            ring [RING_DEPTH];
        int unsigned      wr_ptr;
        int unsigned      rd_ptr;
        logic [TAG_W-1:0] seen_tag;
        logic [OVR_W-1:0] missed;
        rx_result_t       expected_q [$];
        int               errors;

        function new();
            wr_ptr   = 0;
            rd_ptr   = 0;
            seen_tag = '0;
            missed   = '0;
            errors   = 0;
        endfunction

        function int unsigned held();
            return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + RING_DEPTH - rd_ptr;
        endfunction

        function void note_request(logic op, logic [TAG_W-1:0] tag, t_byte data);
            rx_result_t       r;
            logic [TAG_W-1:0] gap;
            logic [OVR_W:0]   sum;
            int unsigned      nxt;
            r = '0;
            if (op == OP_POLL) begin
                if (tag != seen_tag) begin
                    gap      = tag - seen_tag - 1'b1;
                    sum      = {1'b0, missed} + gap;
                    missed   = sum[OVR_W] ? {OVR_W{1'b1}} : sum[OVR_W-1:0];
                    seen_tag = tag;
                    nxt      = (wr_ptr + 1 == RING_DEPTH) ? 0 : wr_ptr + 1;
                    if (nxt == rd_ptr) begin
                        r.byte_dropped = 1'b1;
                    end else begin
                        ring[wr_ptr] = data;
                        wr_ptr       = nxt;
                    end
                end
            end else if (wr_ptr != rd_ptr) begin
                r.read_data  = ring[rd_ptr];
                r.read_valid = 1'b1;
                rd_ptr       = (rd_ptr + 1 == RING_DEPTH) ? 0 : rd_ptr + 1;
            end
            r.overrun_total = missed;
            r.fill_level    = FILL_W'(held());
            expected_q.push_back(r);
        endfunction

        function void check_result(rx_result_t got);
            rx_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result transaction with no request pending");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.read_data !== exp_r.read_data) begin
                $error("read_data: expected %0h, got %0h", exp_r.read_data, got.read_data);
                errors++;
            end
            if (got.read_valid !== exp_r.read_valid) begin
                $error("read_valid: expected %0b, got %0b", exp_r.read_valid, got.read_valid);
                errors++;
            end
            if (got.byte_dropped !== exp_r.byte_dropped) begin
                $error("byte_dropped: expected %0b, got %0b",
                       exp_r.byte_dropped, got.byte_dropped);
                errors++;
            end
            if (got.overrun_total !== exp_r.overrun_total) begin
                $error("overrun_total: expected %0d, got %0d",
                       exp_r.overrun_total, got.overrun_total);
                errors++;
            end
            if (got.fill_level !== exp_r.fill_level) begin
                $error("fill_level: expected %0d, got %0d", exp_r.fill_level, got.fill_level);
                errors++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int send_idle_pct = 20;
    int recv_idle_pct = 48;
    int stall_cycles  = 0;

    rx_fifo_scoreboard sb;

    srfoc_in_if  in_ch ();
    srfoc_out_if out_ch ();

    serial_receive_fifo_overrun_count i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // receiver stalls
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result({out_ch.read_data, out_ch.read_valid, out_ch.byte_dropped,
                             out_ch.overrun_total, out_ch.fill_level});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // called and returns at a falling edge
    task automatic send_item(logic op, logic [TAG_W-1:0] tag, t_byte data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_tag    <= tag;
        in_ch.rx_data   <= data;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        sb.note_request(op, tag, data);
        @(negedge i_clk);
    endtask

    task automatic run_random(int count);
        int kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                send_item(OP_READ, TAG_W'($urandom_range(255)), t_byte'($urandom_range(255)));
            end else if (kind < 80) begin
                send_item(OP_POLL, TAG_W'(sb.seen_tag + 1), t_byte'($urandom_range(255)));
            end else if (kind < 88) begin
                send_item(OP_POLL, sb.seen_tag, t_byte'($urandom_range(255)));
            end else begin
                send_item(OP_POLL, TAG_W'($urandom_range(255)), t_byte'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        sb              = new();
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_POLL;
        in_ch.rx_tag    = '0;
        in_ch.rx_data   = '0;
        out_ch.ready    = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty read, repeated tag, tag wrap and largest gaps
        send_item(OP_READ, 8'hFF, 8'hFF);
        send_item(OP_POLL, 8'h00, 8'hFF);
        send_item(OP_POLL, 8'h01, 8'h00);
        send_item(OP_POLL, 8'h01, 8'hAA);
        send_item(OP_POLL, 8'hFF, 8'hFF);
        send_item(OP_POLL, 8'h00, 8'h5A);
        send_item(OP_POLL, 8'hFF, 8'hA5);
        send_item(OP_POLL, 8'h01, 8'h3C);
        send_item(OP_POLL, 8'h80, 8'h7F);
        send_item(OP_POLL, 8'h7F, 8'h80);
        repeat (8) send_item(OP_READ, 8'h00, 8'h00);
        send_item(OP_POLL, 8'h80, 8'hC3);
        send_item(OP_READ, 8'hFF, 8'hFF);

        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 48;
        recv_idle_pct = 20;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);

        // fill to the brim, overflow, then read a few back
        while (sb.held() < RING_DEPTH - 1) begin
            send_item(OP_POLL, TAG_W'(sb.seen_tag + 1), t_byte'($urandom_range(255)));
        end
        repeat (6) begin
            send_item(OP_POLL, TAG_W'(sb.seen_tag + $urandom_range(1, 255)),
                      t_byte'($urandom_range(255)));
        end
        send_item(OP_POLL, sb.seen_tag, t_byte'($urandom_range(255)));
        repeat (16) begin
            send_item(OP_READ, TAG_W'($urandom_range(255)), t_byte'($urandom_range(255)));
        end
        run_random(ITEMS_PER_PHASE / 4);

        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
